@@ hw/rtl/lacr_pkg.sv @@
// lacr_pkg: shared types and helpers for the look-at camera rotation block
// holds the result struct and the output sign encoder; no dependencies
`default_nettype none

package lacr_pkg;

   localparam int OUT_WIDTH = 16;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] side_x;
      logic [OUT_WIDTH-1:0] side_y;
      logic [OUT_WIDTH-1:0] side_z;
      logic [OUT_WIDTH-1:0] up_x;
      logic [OUT_WIDTH-1:0] up_y;
      logic [OUT_WIDTH-1:0] up_z;
      logic [OUT_WIDTH-1:0] view_x;
      logic [OUT_WIDTH-1:0] view_y;
      logic [OUT_WIDTH-1:0] view_z;
      logic                 vertical_flag;
      logic                 zero_distance_flag;
   } lacr_axes_type;

   // apply sign to a magnitude and keep the low output bits
   function automatic logic [OUT_WIDTH-1:0] enc(input logic [31:0] mag, input logic neg);
      logic [31:0] t;
      t = neg ? (~mag + 32'd1) : mag;
      return t[OUT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/look_at_camera_rotation.sv @@
// look_at_camera_rotation: fully pipelined look-at rotation, one item per cycle unless a result is stalled
// the pipe depth is set by the 32 steps of the two square-root pipes and by the
// quotient bits of the divider lanes
// throughput is one item per cycle; a stalled result holds the whole pipe in place
// synchronous active-high reset clears all valid bits; the data path is not reset
// depends on lacr_pkg
`default_nettype none

module look_at_camera_rotation
   import lacr_pkg::*;
#(
   parameter int COORD_BITS    = 32,
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_cam_x,
   input  wire logic signed [COORD_BITS-1:0] req_cam_y,
   input  wire logic signed [COORD_BITS-1:0] req_cam_z,
   input  wire logic signed [COORD_BITS-1:0] req_target_x,
   input  wire logic signed [COORD_BITS-1:0] req_target_y,
   input  wire logic signed [COORD_BITS-1:0] req_target_z,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic signed [15:0]           rsp_side_x,
   output      logic signed [15:0]           rsp_side_y,
   output      logic signed [15:0]           rsp_side_z,
   output      logic signed [15:0]           rsp_up_x,
   output      logic signed [15:0]           rsp_up_y,
   output      logic signed [15:0]           rsp_up_z,
   output      logic signed [15:0]           rsp_view_x,
   output      logic signed [15:0]           rsp_view_y,
   output      logic signed [15:0]           rsp_view_z,
   output      logic                         rsp_vertical_flag,
   output      logic                         rsp_zero_distance_flag
);

   localparam int DW   = COORD_BITS + 1;
   localparam int MW   = (DW > 31) ? DW : 31;
   localparam int KW   = $clog2(MW);
   localparam int DF   = (OUT_FRAC_BITS + 1 > 30) ? OUT_FRAC_BITS + 1 : 30;
   localparam int LAT  = 40 + DF;
   localparam int PSH  = 60 - OUT_FRAC_BITS;

   function automatic logic [63:0] isqrt_const(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] b;
      r = '0;
      x = v;
      for (int i = 0; i < 32; i++) begin
         b = 64'd1 << (62 - 2 * i);
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   localparam logic [31:0] DIAG =
      32'((isqrt_const(64'd1 << (2 * OUT_FRAC_BITS + 1)) + 64'd1) >> 1);
   localparam logic [31:0] ONE = 32'd1 << OUT_FRAC_BITS;

   typedef struct packed {
      logic [63:0]       hv;
      logic [63:0]       hr;
      logic [63:0]       sv;
      logic [63:0]       sr;
      logic [2:0][30:0]  a;
      logic [2:0]        neg;
      logic              zero;
      logic              vert;
   } sq_type;

   typedef struct packed {
      logic [5:0][32:0]  rem;
      logic [5:0][DF:0]  q;
      logic [32:0]       nd;
      logic [32:0]       hd;
      logic [2:0]        neg;
      logic              zero;
      logic              vert;
   } dv_type;

   typedef struct packed {
      logic [61:0]       px;
      logic [61:0]       py;
      logic [5:0][31:0]  rat;
      logic [2:0]        neg;
      logic              zero;
      logic              vert;
   } mu_type;

   function automatic sq_type sq_step(input sq_type x, input int j);
      sq_type y;
      logic [63:0] b;
      y = x;
      b = 64'd1 << (62 - 2 * j);
      if (x.hv >= x.hr + b) begin
         y.hv = x.hv - (x.hr + b);
         y.hr = (x.hr >> 1) + b;
      end else begin
         y.hr = x.hr >> 1;
      end
      if (x.sv >= x.sr + b) begin
         y.sv = x.sv - (x.sr + b);
         y.sr = (x.sr >> 1) + b;
      end else begin
         y.sr = x.sr >> 1;
      end
      return y;
   endfunction

   // one restoring quotient bit per lane; lanes 0,1 divide by h, the rest by n
   function automatic dv_type dv_step(input dv_type x, input logic first);
      dv_type y;
      logic [32:0] t;
      logic [32:0] dd;
      y = x;
      for (int l = 0; l < 6; l++) begin
         t  = first ? x.rem[l] : {x.rem[l][31:0], 1'b0};
         dd = (l < 2) ? x.hd : x.nd;
         if (t >= dd) begin
            y.rem[l] = t - dd;
            y.q[l]   = {x.q[l][DF-1:0], 1'b1};
         end else begin
            y.rem[l] = t;
            y.q[l]   = {x.q[l][DF-1:0], 1'b0};
         end
      end
      return y;
   endfunction

   logic               advance;
   logic [LAT-1:0]     vld_ff;

   logic signed [COORD_BITS-1:0] cam [3];
   logic signed [COORD_BITS-1:0] tgt [3];
   logic [2:0][MW-1:0] s1_mag_in;
   logic [2:0]         s1_neg_in;
   logic [2:0][MW-1:0] s1_mag_ff;
   logic [2:0]         s1_neg_ff;

   logic [MW-1:0]      orv;
   logic [KW-1:0]      shamt;
   logic [2:0][30:0]   s2_a_in;
   logic [2:0][30:0]   s2_a_ff;
   logic [2:0]         s2_neg_ff;
   logic               s2_zero_in;
   logic               s2_zero_ff;

   logic [2:0][61:0]   s3_sq_in;
   logic [2:0][61:0]   s3_sq_ff;
   logic [2:0][30:0]   s3_a_ff;
   logic [2:0]         s3_neg_ff;
   logic               s3_zero_ff;

   logic [62:0]        h2;
   logic [63:0]        s2;
   sq_type             sq_in [33];
   sq_type             sq_ff [33];
   dv_type             dv_in [DF+2];
   dv_type             dv_ff [DF+2];
   mu_type             mu_in;
   mu_type             mu_ff;
   logic [61:0]        rnd_x;
   logic [61:0]        rnd_y;
   lacr_axes_type      out_in;
   lacr_axes_type      out_ff;

   assign advance   = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: differences and magnitudes
   always_comb begin
      logic signed [DW-1:0] d;
      logic [DW-1:0]        m;
      cam[0] = req_cam_x;
      cam[1] = req_cam_y;
      cam[2] = req_cam_z;
      tgt[0] = req_target_x;
      tgt[1] = req_target_y;
      tgt[2] = req_target_z;
      for (int i = 0; i < 3; i++) begin
         d = $signed({tgt[i][COORD_BITS-1], tgt[i]}) - $signed({cam[i][COORD_BITS-1], cam[i]});
         m = d[DW-1] ? DW'(-d) : DW'(d);
         s1_neg_in[i] = d[DW-1];
         s1_mag_in[i] = MW'(m);
      end
   end

   // stage 2: common right shift so the largest magnitude is below 2^31
   always_comb begin
      orv   = s1_mag_ff[0] | s1_mag_ff[1] | s1_mag_ff[2];
      shamt = '0;
      for (int j = 31; j < MW; j++) begin
         if (orv[j]) begin
            shamt = KW'(j - 30);
         end
      end
      for (int i = 0; i < 3; i++) begin
         s2_a_in[i] = 31'(s1_mag_ff[i] >> shamt);
      end
      s2_zero_in = (orv == '0);
   end

   // stage 3: squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_sq_in[i] = 62'(s2_a_ff[i]) * 62'(s2_a_ff[i]);
      end
   end

   // stage 4: sums and near-vertical test, then into the root pipes
   always_comb begin
      h2 = 63'(s3_sq_ff[0]) + 63'(s3_sq_ff[1]);
      s2 = 64'(h2) + 64'(s3_sq_ff[2]);
      sq_in[0].hv   = 64'(h2);
      sq_in[0].hr   = '0;
      sq_in[0].sv   = s2;
      sq_in[0].sr   = '0;
      sq_in[0].a    = s3_a_ff;
      sq_in[0].neg  = s3_neg_ff;
      sq_in[0].zero = s3_zero_ff;
      sq_in[0].vert = (h2 == '0) || (64'(h2) <= ((s2 - 64'd1) >> 40));
      for (int j = 0; j < 32; j++) begin
         sq_in[j+1] = sq_step(sq_ff[j], j);
      end
   end

   // divider lanes: ax/h, ay/h, ax/n, ay/n, az/n, h/n
   always_comb begin
      dv_in[0].rem[0] = 33'(sq_ff[32].a[0]);
      dv_in[0].rem[1] = 33'(sq_ff[32].a[1]);
      dv_in[0].rem[2] = 33'(sq_ff[32].a[0]);
      dv_in[0].rem[3] = 33'(sq_ff[32].a[1]);
      dv_in[0].rem[4] = 33'(sq_ff[32].a[2]);
      dv_in[0].rem[5] = 33'(sq_ff[32].hr[31:0]);
      dv_in[0].q      = '0;
      dv_in[0].nd     = 33'(sq_ff[32].sr[31:0]);
      dv_in[0].hd     = 33'(sq_ff[32].hr[31:0]);
      dv_in[0].neg    = sq_ff[32].neg;
      dv_in[0].zero   = sq_ff[32].zero;
      dv_in[0].vert   = sq_ff[32].vert;
      for (int s = 0; s <= DF; s++) begin
         dv_in[s+1] = dv_step(dv_ff[s], s == 0);
      end
   end

   // products of 31-bit ratios and rounded single ratios
   always_comb begin
      logic [OUT_FRAC_BITS+1:0] tq;
      mu_in.px = 62'(dv_ff[DF+1].q[0][DF:DF-30]) * 62'(dv_ff[DF+1].q[4][DF:DF-30]);
      mu_in.py = 62'(dv_ff[DF+1].q[1][DF:DF-30]) * 62'(dv_ff[DF+1].q[4][DF:DF-30]);
      for (int l = 0; l < 6; l++) begin
         tq = dv_ff[DF+1].q[l][DF:DF-OUT_FRAC_BITS-1];
         mu_in.rat[l] = 32'((tq + (OUT_FRAC_BITS+2)'(1)) >> 1);
      end
      mu_in.neg  = dv_ff[DF+1].neg;
      mu_in.zero = dv_ff[DF+1].zero;
      mu_in.vert = dv_ff[DF+1].vert;
   end

   // final rounding, signs and special cases
   always_comb begin
      rnd_x = (mu_ff.px + (62'd1 << (PSH - 1))) >> PSH;
      rnd_y = (mu_ff.py + (62'd1 << (PSH - 1))) >> PSH;
      out_in = '0;
      priority if (mu_ff.zero) begin
         out_in.zero_distance_flag = 1'b1;
      end else if (mu_ff.vert) begin
         out_in.side_x        = enc(DIAG, 1'b1);
         out_in.side_y        = enc(DIAG, 1'b0);
         out_in.up_x          = enc(DIAG, !mu_ff.neg[2]);
         out_in.up_y          = enc(DIAG, !mu_ff.neg[2]);
         out_in.view_z        = enc(ONE, mu_ff.neg[2]);
         out_in.vertical_flag = 1'b1;
      end else begin
         out_in.side_x = enc(mu_ff.rat[1], !mu_ff.neg[1]);
         out_in.side_y = enc(mu_ff.rat[0], mu_ff.neg[0]);
         out_in.up_x   = enc(32'(rnd_x), mu_ff.neg[0] == mu_ff.neg[2]);
         out_in.up_y   = enc(32'(rnd_y), mu_ff.neg[1] == mu_ff.neg[2]);
         out_in.up_z   = enc(mu_ff.rat[5], 1'b0);
         out_in.view_x = enc(mu_ff.rat[2], mu_ff.neg[0]);
         out_in.view_y = enc(mu_ff.rat[3], mu_ff.neg[1]);
         out_in.view_z = enc(mu_ff.rat[4], mu_ff.neg[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mag_ff  <= s1_mag_in;
         s1_neg_ff  <= s1_neg_in;
         s2_a_ff    <= s2_a_in;
         s2_neg_ff  <= s1_neg_ff;
         s2_zero_ff <= s2_zero_in;
         s3_sq_ff   <= s3_sq_in;
         s3_a_ff    <= s2_a_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_zero_ff <= s2_zero_ff;
         for (int j = 0; j < 33; j++) begin
            sq_ff[j] <= sq_in[j];
         end
         for (int s = 0; s < DF + 2; s++) begin
            dv_ff[s] <= dv_in[s];
         end
         mu_ff  <= mu_in;
         out_ff <= out_in;
      end
   end

   assign rsp_side_x             = out_ff.side_x;
   assign rsp_side_y             = out_ff.side_y;
   assign rsp_side_z             = out_ff.side_z;
   assign rsp_up_x               = out_ff.up_x;
   assign rsp_up_y               = out_ff.up_y;
   assign rsp_up_z               = out_ff.up_z;
   assign rsp_view_x             = out_ff.view_x;
   assign rsp_view_y             = out_ff.view_y;
   assign rsp_view_z             = out_ff.view_z;
   assign rsp_vertical_flag      = out_ff.vertical_flag;
   assign rsp_zero_distance_flag = out_ff.zero_distance_flag;

endmodule

`default_nettype wire

@@ verif/tb_look_at_camera_rotation.sv @@
// tb_look_at_camera_rotation: self-checking bench for the look-at camera rotation block
// drives position/target items with random gaps, predicts each rotation in fixed point
// depends on lacr_pkg and look_at_camera_rotation
`default_nettype none

module tb_look_at_camera_rotation;
   import lacr_pkg::*;

   localparam int CB = 32;
   localparam int FB = 14;
   localparam int LATENCY = 70;
   localparam logic [CB-1:0] MAXC = 32'h7fffffff;
   localparam logic [CB-1:0] MINC = 32'h80000000;

   typedef struct packed {
      logic [CB-1:0] cx, cy, cz, tx, ty, tz;
   } pose_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_cam_x = '0, req_cam_y = '0, req_cam_z = '0;
   logic signed [CB-1:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_side_x, rsp_side_y, rsp_side_z, rsp_up_x, rsp_up_y, rsp_up_z;
   logic signed [15:0] rsp_view_x, rsp_view_y, rsp_view_z;
   logic rsp_vertical_flag, rsp_zero_distance_flag;

   look_at_camera_rotation dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pose_req_type  pending_poses[$];
   lacr_axes_type expected_axes[$];
   int  error_count = 0;
   bit  stimulus_done = 1'b0;
   bit  hold_sender = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] frac_round(input logic [63:0] u, input logic [63:0] v);
      logic [63:0] q;
      q = (u << (FB + 1)) / v;
      return (q + 1) >> 1;
   endfunction

   function automatic logic [63:0] prod_round(input logic [63:0] u1, input logic [63:0] v1,
                                              input logic [63:0] u2, input logic [63:0] v2);
      logic [63:0] p;
      p = ((u1 << 30) / v1) * ((u2 << 30) / v2);
      return (p + (64'd1 << (59 - FB))) >> (60 - FB);
   endfunction

   function automatic logic [15:0] signed_out(input logic [63:0] mag, input bit neg);
      logic [63:0] t;
      t = neg ? -mag : mag;
      return t[15:0];
   endfunction

   function automatic lacr_axes_type predict_rotation(input pose_req_type p);
      lacr_axes_type r;
      logic signed [63:0] d[3];
      logic [63:0] mag[3], a[3], m, h2, s2, n, h, c;
      bit neg[3];
      int k;
      r = '0;
      d[0] = 64'(signed'(p.tx)) - 64'(signed'(p.cx));
      d[1] = 64'(signed'(p.ty)) - 64'(signed'(p.cy));
      d[2] = 64'(signed'(p.tz)) - 64'(signed'(p.cz));
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = d[i] < 0;
         mag[i] = neg[i] ? -d[i] : d[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         r.zero_distance_flag = 1'b1;
         return r;
      end
      k = 0;
      while ((m >> k) >= (64'd1 << 31)) k++;
      for (int i = 0; i < 3; i++) a[i] = mag[i] >> k;
      h2 = a[0] * a[0] + a[1] * a[1];
      s2 = h2 + a[2] * a[2];
      n = root64(s2);
      h = root64(h2);
      if (h2 == 0 || h2 <= ((s2 - 1) >> 40)) begin
         // looking straight or nearly straight up or down: fixed side axis
         c = (root64(64'd1 << (2 * FB + 1)) + 1) >> 1;
         r.side_x = signed_out(c, 1'b1);
         r.side_y = signed_out(c, 1'b0);
         r.up_x = signed_out(c, !neg[2]);
         r.up_y = signed_out(c, !neg[2]);
         r.view_z = signed_out(64'd1 << FB, neg[2]);
         r.vertical_flag = 1'b1;
         return r;
      end
      r.side_x = signed_out(frac_round(a[1], h), !neg[1]);
      r.side_y = signed_out(frac_round(a[0], h), neg[0]);
      r.up_x = signed_out(prod_round(a[0], h, a[2], n), neg[0] == neg[2]);
      r.up_y = signed_out(prod_round(a[1], h, a[2], n), neg[1] == neg[2]);
      r.up_z = signed_out(frac_round(h, n), 1'b0);
      r.view_x = signed_out(frac_round(a[0], n), neg[0]);
      r.view_y = signed_out(frac_round(a[1], n), neg[1]);
      r.view_z = signed_out(frac_round(a[2], n), neg[2]);
      return r;
   endfunction

   // driver: one item from the queue per handshake, random gap between items
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_axes.push_back(predict_rotation({req_cam_x, req_cam_y, req_cam_z,
               req_target_x, req_target_y, req_target_z}));
            send_gap = $urandom_range(0, 7);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_poses.size() > 0 && !hold_sender) begin
               pose_req_type p;
               p = pending_poses.pop_front();
               req_cam_x <= p.cx;
               req_cam_y <= p.cy;
               req_cam_z <= p.cz;
               req_target_x <= p.tx;
               req_target_y <= p.ty;
               req_target_z <= p.tz;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
         error_count++;
      end
   endtask

   // monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_axes.size() == 0) begin
               $display("%0t: unexpected result item", $time);
               error_count++;
            end else begin
               lacr_axes_type e;
               e = expected_axes.pop_front();
               report_field("side_x", e.side_x, rsp_side_x);
               report_field("side_y", e.side_y, rsp_side_y);
               report_field("side_z", e.side_z, rsp_side_z);
               report_field("up_x", e.up_x, rsp_up_x);
               report_field("up_y", e.up_y, rsp_up_y);
               report_field("up_z", e.up_z, rsp_up_z);
               report_field("view_x", e.view_x, rsp_view_x);
               report_field("view_y", e.view_y, rsp_view_y);
               report_field("view_z", e.view_z, rsp_view_z);
               report_field("vertical_flag", e.vertical_flag, rsp_vertical_flag);
               report_field("zero_distance_flag", e.zero_distance_flag,
                  rsp_zero_distance_flag);
            end
            recv_gap = $urandom_range(0, 7);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [CB-1:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 2000) - 1000;
         2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
         default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      endcase
   endfunction

   task automatic add_pose(input logic [CB-1:0] cx, cy, cz, tx, ty, tz);
      pending_poses.push_back({cx, cy, cz, tx, ty, tz});
   endtask

   initial begin
      pose_req_type p;
      int mode;
      // zero distance
      add_pose(0, 0, 0, 0, 0, 0);
      add_pose(MAXC, MINC, 5, MAXC, MINC, 5);
      // straight up and down
      add_pose(0, 0, 0, 0, 0, 32'h10000);
      add_pose(0, 0, 0, 0, 0, -32'sd1);
      add_pose(1, 2, MINC, 1, 2, MAXC);
      add_pose(1, 2, MAXC, 1, 2, MINC);
      // horizontal part below, at and above the vertical threshold
      add_pose(0, 0, MINC, 0, 1, MAXC);
      add_pose(0, 0, 0, 1, 0, 32'h00100000);
      add_pose(0, 0, 0, 1, 1, 1);
      // extremes of every coordinate, then small and mid-range offsets
      add_pose(MINC, MINC, MINC, MAXC, MAXC, MAXC);
      add_pose(MAXC, MAXC, MAXC, MINC, MINC, MINC);
      add_pose(MINC, MAXC, 0, MAXC, MINC, 0);
      add_pose(0, 0, 0, MAXC, 0, 0);
      add_pose(0, 0, 0, 0, MINC, 0);
      add_pose(0, 0, 0, -32'sd1, -32'sd1, -32'sd1);
      add_pose(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0);
      add_pose(0, 0, 0, 3, -4, 0);
      add_pose(0, 0, 0, -5, 12, 13);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_poses.size() == 0 && !req_valid);
      wait (expected_axes.size() == 0);
      // sender pauses until the pipe drains, then resumes
      for (int i = 0; i < 1250; i++) begin
         mode = $urandom_range(0, 3);
         p.cx = rand_coord(mode); p.cy = rand_coord(mode); p.cz = rand_coord(mode);
         if ($urandom_range(0, 9) == 0) begin
            p.tx = p.cx; p.ty = p.cy;
            p.tz = ($urandom_range(0, 3) == 0) ? p.cz : rand_coord(mode);
         end else begin
            p.tx = rand_coord(mode); p.ty = rand_coord(mode); p.tz = rand_coord(mode);
         end
         pending_poses.push_back(p);
         if (i == 600) begin
            wait (pending_poses.size() == 0 && !req_valid);
            hold_sender = 1'b1;
            wait (expected_axes.size() == 0);
            hold_sender = 1'b0;
         end
      end
      wait (pending_poses.size() == 0 && !req_valid);
      wait (expected_axes.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("tb_look_at_camera_rotation: clean");
      else
         $display("tb_look_at_camera_rotation: errors");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_look_at_camera_rotation: errors");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/lacr_pkg.sv
hw/rtl/look_at_camera_rotation.sv
verif/tb_look_at_camera_rotation.sv
